FILE: sv/dirty_tile_run_tracker_assert.svh
// Assertion macros for the dirty tile run tracker.
// Included by the top level; needs nothing else.
`ifndef DIRTY_TILE_RUN_TRACKER_ASSERT_SVH
`define DIRTY_TILE_RUN_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, off while reset is high
`define DTR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define DTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DTR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define DTR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/dtr_pkg.sv
// Shared types, constants and helper functions of the dirty tile run tracker.
// No dependencies; imported by dtr_div, the top level and the bench.
package dtr_pkg;

   localparam int WORD_W        = 32;   // bitmap word, tiles per RAM entry
   localparam int BIT_W         = 5;    // bit position within a word
   localparam int CFG_W         = 13;   // screen size and rectangle fields
   localparam int SHIFT_W       = 3;
   localparam int PROD_W        = 26;   // 13 x 13 product
   localparam int RUN_X_W       = 12;
   localparam int RUN_W_W       = 13;
   localparam int RUN_H_W       = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int DEF_MAX_TILES = 8192;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SHIFT    = 2'd2;

   // request modes
   localparam logic MODE_MARK  = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   localparam logic [CFG_W-1:0]   RST_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0]   RST_HEIGHT = 13'd480;
   localparam logic [SHIFT_W-1:0] RST_SHIFT  = 3'd3;
   localparam logic [SHIFT_W-1:0] MAX_SHIFT  = 3'd4;

   typedef logic [WORD_W-1:0] dtr_word_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } dtr_find_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dtr_div_stat_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_M_CLIP,
      ST_M_BASE,
      ST_M_ROW,
      ST_M_RD,
      ST_M_WR,
      ST_M_OUT,
      ST_F_LIM,
      ST_F_RD,
      ST_F_CHK,
      ST_F_DIV,
      ST_F_EXT,
      ST_F_XRD,
      ST_F_XLD,
      ST_F_OUT,
      ST_F_DONE
   } dtr_state_type;

   // lowest set bit of a word
   function automatic dtr_find_type find_first(input dtr_word_type v);
      dtr_find_type f;
      f.found = 1'b0;
      f.pos   = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (v[b]) begin
            f.found = 1'b1;
            f.pos   = BIT_W'(b);
         end
      end
      return f;
   endfunction

   // ones at and above bit lo
   function automatic dtr_word_type mask_from(input logic [BIT_W-1:0] lo);
      dtr_word_type m;
      m = '1;
      return m << lo;
   endfunction

   // ones at and below bit hi
   function automatic dtr_word_type mask_to(input logic [BIT_W-1:0] hi);
      dtr_word_type m;
      m = '1;
      return m >> (BIT_W'(WORD_W - 1) - hi);
   endfunction

endpackage

FILE: sv/dtr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the tile bitmap; depends on nothing.
module dtr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/dtr_div.sv
// Restoring divider, one quotient bit per cycle.
// Splits a tile index into row and column; uses dtr_pkg.
module dtr_div
   import dtr_pkg::*;
#(
   parameter int DW = 14,
   parameter int VW = CFG_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DW-1:0]    dividend,
   input  logic [VW-1:0]    divisor,
   output dtr_div_stat_type stat,
   output logic [DW-1:0]    quotient,
   output logic [VW-1:0]    remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = VW'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/dirty_tile_run_tracker.sv
// Top level of the dirty tile run tracker: sequencer, tile bitmap, divider.
// Uses dtr_pkg, dtr_ram, dtr_div and dirty_tile_run_tracker_assert.svh.
//
// Requests arrive on req_* (valid/ready). Mode mark clips a rectangle to the
// screen and sets every tile it touches; mode fetch returns the next run of
// dirty tiles in raster order, or run_valid = 0 once the map is exhausted.
// Each request gives exactly one response on rsp_* (valid/ready), held in an
// output register. Screen size and tile shift are set through csr_*; the user
// must write them only while the block is idle; the block does not check.
// req_ready is high only while the sequencer is idle; one request at a time.
// Mark: clip, first row base, then for each tile row one read-modify-write per
// bitmap word touched (the RAM has a single read port), then the response.
// Fetch: scan limit, then a read of each bitmap word scanned, the row/col
// divider, a read of each further word of the run, and loading the response.
// A fetch that finds no run clears the map: a pass over all MAP_WORDS words
// (256 at the default size) during which req_ready is low.
// After reset the same clearing pass runs before the first request.
// If the receiver stalls, a finished response waits in the output register
// and the sequencer holds before loading the next one.
module dirty_tile_run_tracker
   import dtr_pkg::*;
#(
   parameter int MAX_TILES = DEF_MAX_TILES
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_mode,
   input  logic signed [CFG_W-1:0]    req_rect_x,
   input  logic signed [CFG_W-1:0]    req_rect_y,
   input  logic [CFG_W-1:0]           req_rect_w,
   input  logic [CFG_W-1:0]           req_rect_h,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_rect_accepted,
   output logic                       rsp_run_valid,
   output logic [RUN_X_W-1:0]         rsp_run_x,
   output logic [RUN_X_W-1:0]         rsp_run_y,
   output logic [RUN_W_W-1:0]         rsp_run_w,
   output logic [RUN_H_W-1:0]         rsp_run_h,
   // configuration writes
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_data
);

`include "dirty_tile_run_tracker_assert.svh"

   localparam int CUR_W     = $clog2(MAX_TILES + WORD_W);
   localparam int MAP_WORDS = (MAX_TILES + WORD_W - 1) / WORD_W;
   localparam int WAW       = $clog2(MAP_WORDS > 1 ? MAP_WORDS : 2);
   localparam int NW        = ((CUR_W > CFG_W) ? CUR_W : CFG_W) + 5;
   localparam logic [CUR_W-1:0]  MAX_IDX   = CUR_W'(MAX_TILES);
   localparam logic [PROD_W-1:0] MAX_PROD  = PROD_W'(MAX_TILES);
   localparam logic [WAW-1:0]    LAST_WORD = WAW'(MAP_WORDS - 1);

   dtr_state_type state_ff, state_in;

   // configuration
   logic [CFG_W-1:0]   cfg_width_ff, cfg_height_ff;
   logic [SHIFT_W-1:0] cfg_shift_ff;

   // captured request
   logic signed [CFG_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [CFG_W-1:0]        rw_ff, rw_in, rh_ff, rh_in;

   // mark walk
   logic              mk_acc_ff, mk_acc_in;
   logic [CFG_W-1:0]  c0_ff, c0_in, c1_ff, c1_in, r_ff, r_in, r1_ff, r1_in;
   logic [PROD_W-1:0] base_ff, base_in;
   logic [WAW-1:0]    w_ff, w_in, wbeg_ff, wbeg_in, wend_ff, wend_in;
   logic [BIT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;

   // fetch scan
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [CUR_W-1:0]  limit_ff, limit_in;
   logic [CUR_W-1:0]  j_ff, j_in, stop_ff, stop_in, end_ff, end_in;
   logic [CUR_W-1:0]  row_ff, row_in;
   logic [CFG_W-1:0]  col_ff, col_in;
   dtr_word_type      word_ff, word_in;

   // clearing pass
   logic [WAW-1:0]    clr_ff, clr_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_acc_ff, rsp_acc_in, rsp_rv_ff, rsp_rv_in;
   logic [RUN_X_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [RUN_W_W-1:0] rsp_w_ff, rsp_w_in;
   logic [RUN_H_W-1:0] rsp_h_ff, rsp_h_in;

   // RAM, multiplier, divider
   logic              ram_we;
   logic [WAW-1:0]    ram_waddr, ram_raddr;
   dtr_word_type      ram_wdata, ram_rdata;
   logic [CFG_W-1:0]  mul_a;
   logic [PROD_W-1:0] mul_prod;
   logic              div_start;
   logic [CUR_W-1:0]  div_dividend, div_quot;
   logic [CFG_W-1:0]  div_rem;
   dtr_div_stat_type  div_stat;

   // derived geometry
   logic [SHIFT_W-1:0] s_eff;
   logic [CFG_W-1:0]   cols, rows;

   // rectangle clipping
   logic signed [CFG_W+1:0] x0_s, x1_raw, x1_s, x1_m1, y0_s, y1_raw, y1_s, y1_m1;
   logic signed [CFG_W+1:0] w_lim_s, h_lim_s;
   logic [CFG_W-1:0]        c0_raw, c1_raw, c1_clip, r0_raw, r1_raw, r1_clip;
   logic                    mk_empty, mk_skip;

   // per-step values
   logic [PROD_W-1:0] st_sum, en_sum, en_clip;
   logic [BIT_W-1:0]  lo_eff, hi_eff;
   dtr_find_type      scan_find, ext_find;
   logic [CUR_W-1:0]  scan_cand, scan_next, ext_cand;
   logic [NW-1:0]     row_end, col_sh, row_sh, n_sh;
   logic [CUR_W-1:0]  run_len;
   logic              out_free;

   dtr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dtr_div #(
      .DW (CUR_W),
      .VW (CFG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cols),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // screen in tiles
   assign s_eff = (cfg_shift_ff > MAX_SHIFT) ? MAX_SHIFT : cfg_shift_ff;
   assign cols  = cfg_width_ff >> s_eff;
   assign rows  = cfg_height_ff >> s_eff;

   // shared multiplier: first row base for a mark, tile count for a fetch
   assign mul_a    = (state_ff == ST_F_LIM) ? rows : r_ff;
   assign mul_prod = mul_a * cols;

   // clip the rectangle against the screen
   always_comb begin
      w_lim_s = signed'({2'b00, cfg_width_ff});
      h_lim_s = signed'({2'b00, cfg_height_ff});
      x0_s    = rx_ff[CFG_W-1] ? '0 : signed'({2'b00, rx_ff});
      y0_s    = ry_ff[CFG_W-1] ? '0 : signed'({2'b00, ry_ff});
      x1_raw  = signed'({{2{rx_ff[CFG_W-1]}}, rx_ff}) + signed'({2'b00, rw_ff});
      y1_raw  = signed'({{2{ry_ff[CFG_W-1]}}, ry_ff}) + signed'({2'b00, rh_ff});
      x1_s    = (x1_raw > w_lim_s) ? w_lim_s : x1_raw;
      y1_s    = (y1_raw > h_lim_s) ? h_lim_s : y1_raw;
      x1_m1   = x1_s - 15'sd1;
      y1_m1   = y1_s - 15'sd1;
      c0_raw  = x0_s[CFG_W-1:0] >> s_eff;
      r0_raw  = y0_s[CFG_W-1:0] >> s_eff;
      c1_raw  = x1_m1[CFG_W-1:0] >> s_eff;
      r1_raw  = y1_m1[CFG_W-1:0] >> s_eff;
      c1_clip = (c1_raw >= cols) ? cols - CFG_W'(1) : c1_raw;
      r1_clip = (r1_raw >= rows) ? rows - CFG_W'(1) : r1_raw;
      mk_empty = (rw_ff == '0) || (rh_ff == '0) || (x0_s >= x1_s) || (y0_s >= y1_s);
      mk_skip  = mk_empty || (cols == '0) || (rows == '0) || (c0_raw > c1_clip);
   end

   // row span and word mask for the mark walk
   always_comb begin
      st_sum  = base_ff + PROD_W'(c0_ff);
      en_sum  = base_ff + PROD_W'(c1_ff);
      en_clip = (en_sum >= MAX_PROD) ? MAX_PROD - PROD_W'(1) : en_sum;
      lo_eff  = (w_ff == wbeg_ff) ? lo_ff : '0;
      hi_eff  = (w_ff == wend_ff) ? hi_ff : BIT_W'(WORD_W - 1);
   end

   // bit searches of the fetch scan
   always_comb begin
      scan_find = find_first(ram_rdata & mask_from(cursor_ff[BIT_W-1:0]));
      scan_cand = {cursor_ff[CUR_W-1:BIT_W], scan_find.pos};
      scan_next = (cursor_ff | CUR_W'(WORD_W - 1)) + CUR_W'(1);
      ext_find  = find_first(~word_ff & mask_from(j_ff[BIT_W-1:0]));
      ext_cand  = ext_find.found ? {j_ff[CUR_W-1:BIT_W], ext_find.pos}
                                 : (j_ff | CUR_W'(WORD_W - 1)) + CUR_W'(1);
      row_end   = NW'(cursor_ff) - NW'(div_rem) + NW'(cols);
      run_len   = end_ff - cursor_ff;
      col_sh    = NW'(col_ff) << s_eff;
      row_sh    = NW'(row_ff) << s_eff;
      n_sh      = NW'(run_len) << s_eff;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer: next state, datapath loads, RAM and divider controls
   always_comb begin
      state_in     = state_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rw_in        = rw_ff;
      rh_in        = rh_ff;
      mk_acc_in    = mk_acc_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      r_in         = r_ff;
      r1_in        = r1_ff;
      base_in      = base_ff;
      w_in         = w_ff;
      wbeg_in      = wbeg_ff;
      wend_in      = wend_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cursor_in    = cursor_ff;
      limit_in     = limit_ff;
      j_in         = j_ff;
      stop_in      = stop_ff;
      end_in       = end_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      word_in      = word_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_h_in     = rsp_h_ff;
      ram_we       = 1'b0;
      ram_waddr    = w_ff;
      ram_wdata    = ram_rdata | (mask_from(lo_eff) & mask_to(hi_eff));
      ram_raddr    = w_ff;
      div_start    = 1'b0;
      div_dividend = scan_cand;
      req_ready    = 1'b0;

      unique case (state_ff)
         // zero the bitmap, one word per cycle
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == LAST_WORD) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + WAW'(1);
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rx_in    = req_rect_x;
               ry_in    = req_rect_y;
               rw_in    = req_rect_w;
               rh_in    = req_rect_h;
               state_in = (req_mode == MODE_FETCH) ? ST_F_LIM : ST_M_CLIP;
            end
         end

         // mark: clip and set up the tile span
         ST_M_CLIP: begin
            mk_acc_in = !mk_empty;
            c0_in     = c0_raw;
            c1_in     = c1_clip;
            r_in      = r0_raw;
            r1_in     = r1_clip;
            state_in  = mk_skip ? ST_M_OUT : ST_M_BASE;
         end

         ST_M_BASE: begin
            base_in  = mul_prod;
            state_in = ST_M_ROW;
         end

         // start of one tile row
         ST_M_ROW: begin
            if ((r_ff > r1_ff) || (base_ff >= MAX_PROD) || (st_sum >= MAX_PROD)) begin
               state_in = ST_M_OUT;
            end else begin
               w_in     = WAW'(st_sum >> BIT_W);
               wbeg_in  = WAW'(st_sum >> BIT_W);
               wend_in  = WAW'(en_clip >> BIT_W);
               lo_in    = st_sum[BIT_W-1:0];
               hi_in    = en_clip[BIT_W-1:0];
               state_in = ST_M_RD;
            end
         end

         ST_M_RD: begin
            ram_raddr = w_ff;
            state_in  = ST_M_WR;
         end

         // read-modify-write of one word
         ST_M_WR: begin
            ram_we = 1'b1;
            if (w_ff == wend_ff) begin
               r_in     = r_ff + CFG_W'(1);
               base_in  = base_ff + PROD_W'(cols);
               state_in = ST_M_ROW;
            end else begin
               w_in     = w_ff + WAW'(1);
               state_in = ST_M_RD;
            end
         end

         ST_M_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = mk_acc_ff;
               rsp_rv_in    = 1'b0;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_w_in     = '0;
               rsp_h_in     = '0;
               state_in     = ST_IDLE;
            end
         end

         // fetch: scan limit
         ST_F_LIM: begin
            limit_in = (mul_prod >= MAX_PROD) ? MAX_IDX : CUR_W'(mul_prod);
            state_in = ST_F_RD;
         end

         ST_F_RD: begin
            ram_raddr = WAW'(cursor_ff >> BIT_W);
            state_in  = (cursor_ff >= limit_ff) ? ST_F_DONE : ST_F_CHK;
         end

         // look for the first set tile at or after the cursor
         ST_F_CHK: begin
            word_in = ram_rdata;
            if (scan_find.found) begin
               if (scan_cand >= limit_ff) begin
                  state_in = ST_F_DONE;
               end else begin
                  cursor_in = scan_cand;
                  div_start = 1'b1;
                  state_in  = ST_F_DIV;
               end
            end else begin
               cursor_in = scan_next;
               state_in  = ST_F_RD;
            end
         end

         // row and column of the run start
         ST_F_DIV: begin
            if (div_stat.done) begin
               row_in   = div_quot;
               col_in   = div_rem;
               stop_in  = (row_end >= NW'(limit_ff)) ? limit_ff : CUR_W'(row_end);
               j_in     = cursor_ff;
               state_in = ST_F_EXT;
            end
         end

         // extend the run to the first clear tile, row end or limit
         ST_F_EXT: begin
            if (ext_find.found || (ext_cand >= stop_ff)) begin
               end_in   = (ext_cand >= stop_ff) ? stop_ff : ext_cand;
               state_in = ST_F_OUT;
            end else begin
               j_in     = ext_cand;
               state_in = ST_F_XRD;
            end
         end

         ST_F_XRD: begin
            ram_raddr = WAW'(j_ff >> BIT_W);
            state_in  = ST_F_XLD;
         end

         ST_F_XLD: begin
            word_in  = ram_rdata;
            state_in = ST_F_EXT;
         end

         ST_F_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b0;
               rsp_rv_in    = 1'b1;
               rsp_x_in     = col_sh[RUN_X_W-1:0];
               rsp_y_in     = row_sh[RUN_X_W-1:0];
               rsp_w_in     = n_sh[RUN_W_W-1:0];
               rsp_h_in     = RUN_H_W'(1) << s_eff;
               cursor_in    = end_ff;
               state_in     = ST_IDLE;
            end
         end

         // map exhausted: report, then clear map and cursor
         ST_F_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b0;
               rsp_rv_in    = 1'b0;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_w_in     = '0;
               rsp_h_in     = '0;
               cursor_in    = '0;
               clr_in       = '0;
               state_in     = ST_CLEAR;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RST_WIDTH;
         cfg_height_ff <= RST_HEIGHT;
         cfg_shift_ff  <= RST_SHIFT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_width_ff  <= csr_data;
            CSR_SCREEN_HEIGHT: cfg_height_ff <= csr_data;
            CSR_TILE_SHIFT:    cfg_shift_ff  <= csr_data[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      rw_ff      <= rw_in;
      rh_ff      <= rh_in;
      mk_acc_ff  <= mk_acc_in;
      c0_ff      <= c0_in;
      c1_ff      <= c1_in;
      r_ff       <= r_in;
      r1_ff      <= r1_in;
      base_ff    <= base_in;
      w_ff       <= w_in;
      wbeg_ff    <= wbeg_in;
      wend_ff    <= wend_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      limit_ff   <= limit_in;
      j_ff       <= j_in;
      stop_ff    <= stop_in;
      end_ff     <= end_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      word_ff    <= word_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_rv_ff  <= rsp_rv_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_w_ff   <= rsp_w_in;
      rsp_h_ff   <= rsp_h_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rect_accepted = rsp_acc_ff;
   assign rsp_run_valid     = rsp_rv_ff;
   assign rsp_run_x         = rsp_x_ff;
   assign rsp_run_y         = rsp_y_ff;
   assign rsp_run_w         = rsp_w_ff;
   assign rsp_run_h         = rsp_h_ff;

   // checks
   `DTR_ASSERT_NOW(a_no_write_when_ready, clock, reset, ram_we, !req_ready, "bitmap written while accepting requests")
   `DTR_ASSERT_NOW(a_div_busy_not_ready, clock, reset, div_stat.busy, !req_ready, "divider busy while accepting requests")
   `DTR_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second request taken during work")
   `DTR_ASSERT_NOW(a_cursor_range, clock, reset, state_ff == ST_IDLE, cursor_ff <= MAX_IDX, "scan cursor past tile store")
   `DTR_ASSERT_NOW(a_no_run_zero, clock, reset, rsp_valid && !rsp_run_valid, (rsp_run_x == '0) && (rsp_run_y == '0) && (rsp_run_w == '0) && (rsp_run_h == '0), "run fields set without a run")

endmodule

FILE: verif/tb.sv
// Self-checking bench for dirty_tile_run_tracker: directed and random marks and
// fetches over several screen setups, checked against an in-bench tile bitmap.
// Depends on dtr_pkg and the dirty_tile_run_tracker RTL only.
module tb;
   import dtr_pkg::*;

   localparam int TILE_CAP    = DEF_MAX_TILES;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int HOLD_CYCLES = 500;

   typedef struct {
      logic                    mode;
      logic signed [CFG_W-1:0] x;
      logic signed [CFG_W-1:0] y;
      logic [CFG_W-1:0]        w;
      logic [CFG_W-1:0]        h;
   } tile_req_type;

   typedef struct packed {
      logic               accepted;
      logic               run_valid;
      logic [RUN_X_W-1:0] run_x;
      logic [RUN_X_W-1:0] run_y;
      logic [RUN_W_W-1:0] run_w;
      logic [RUN_H_W-1:0] run_h;
   } tile_rsp_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   logic                    req_mode    = MODE_MARK;
   logic signed [CFG_W-1:0] req_rect_x  = '0;
   logic signed [CFG_W-1:0] req_rect_y  = '0;
   logic [CFG_W-1:0]        req_rect_w  = '0;
   logic [CFG_W-1:0]        req_rect_h  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   logic                    rsp_rect_accepted;
   logic                    rsp_run_valid;
   logic [RUN_X_W-1:0]      rsp_run_x;
   logic [RUN_X_W-1:0]      rsp_run_y;
   logic [RUN_W_W-1:0]      rsp_run_w;
   logic [RUN_H_W-1:0]      rsp_run_h;
   logic                    csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index   = CSR_SCREEN_WIDTH;
   logic [CFG_W-1:0]        csr_data    = '0;

   // bench copy of the tile bitmap, scan cursor and screen setup
   bit [TILE_CAP-1:0] dirty_bits = '0;
   int                scan_pos   = 0;
   int                scr_w      = RST_WIDTH;
   int                scr_h      = RST_HEIGHT;
   int                shift_cfg  = RST_SHIFT;

   tile_req_type pending_req_q[$];
   tile_rsp_type expected_rsp_q[$];
   tile_req_type offered_req;

   int req_count   = 0;
   int rsp_count   = 0;
   int err_count   = 0;
   int cycle_count = 0;
   int hold_left   = 0;
   int hold_tag    = -1;

   dirty_tile_run_tracker #(.MAX_TILES(TILE_CAP)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rect_accepted (rsp_rect_accepted),
      .rsp_run_valid     (rsp_run_valid),
      .rsp_run_x         (rsp_run_x),
      .rsp_run_y         (rsp_run_y),
      .rsp_run_w         (rsp_run_w),
      .rsp_run_h         (rsp_run_h),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #6 clock = ~clock;

   // shift values above the maximum behave as the maximum
   function automatic int tile_log2();
      return (shift_cfg > MAX_SHIFT) ? MAX_SHIFT : shift_cfg;
   endfunction

   // updates the bench bitmap for one request and returns its response
   function automatic tile_rsp_type apply_tile_request(tile_req_type rq);
      tile_rsp_type rs;
      int        s, cols, rows, lim;
      int        px, py, pw, ph, x0, y0, x1, y1, c1, r1, i, n;
      rs   = '0;
      s    = tile_log2();
      cols = scr_w >> s;
      rows = scr_h >> s;
      if (rq.mode == MODE_MARK) begin
         px = rq.x;
         py = rq.y;
         pw = rq.w;
         ph = rq.h;
         x0 = (px < 0) ? 0 : px;
         y0 = (py < 0) ? 0 : py;
         x1 = (px + pw > scr_w) ? scr_w : px + pw;
         y1 = (py + ph > scr_h) ? scr_h : py + ph;
         if (pw != 0 && ph != 0 && x0 < x1 && y0 < y1) begin
            rs.accepted = 1'b1;
            // partial tiles and tiles past the capacity are not stored
            if (cols > 0 && rows > 0) begin
               c1 = (x1 - 1) >> s;
               r1 = (y1 - 1) >> s;
               if (c1 >= cols) c1 = cols - 1;
               if (r1 >= rows) r1 = rows - 1;
               for (int r = y0 >> s; r <= r1 && r * cols < TILE_CAP; r++)
                  for (int c = x0 >> s; c <= c1; c++)
                     if (r * cols + c < TILE_CAP) dirty_bits[r * cols + c] = 1'b1;
            end
         end
      end else begin
         lim = cols * rows;
         if (lim > TILE_CAP) lim = TILE_CAP;
         i = scan_pos;
         while (i < lim && !dirty_bits[i]) i++;
         if (i >= lim || cols == 0) begin
            // nothing left: wipe the map and restart the scan
            dirty_bits = '0;
            scan_pos   = 0;
         end else begin
            n = 1;
            while (i + n < lim && dirty_bits[i + n] && (i + n) / cols == i / cols) n++;
            scan_pos     = i + n;
            rs.run_valid = 1'b1;
            rs.run_x     = RUN_X_W'((i % cols) << s);
            rs.run_y     = RUN_X_W'((i / cols) << s);
            rs.run_w     = RUN_W_W'(n << s);
            rs.run_h     = RUN_H_W'(1 << s);
         end
      end
      return rs;
   endfunction

   // idle percentage by traffic stage: sender-heavy, receiver-heavy, none
   function automatic int idle_pct(bit receiver);
      if (req_count < 140) return receiver ? 57 : 20;
      if (req_count < 280) return receiver ? 20 : 57;
      return 0;
   endfunction

   function automatic tile_req_type make_req(logic mode, int x, int y, int w, int h);
      tile_req_type rq;
      rq.mode = mode;
      rq.x    = CFG_W'(x);
      rq.y    = CFG_W'(y);
      rq.w    = CFG_W'(w);
      rq.h    = CFG_W'(h);
      return rq;
   endfunction

   // rectangle around the current screen, mostly small, sometimes huge
   function automatic tile_req_type rand_mark();
      int side, x, y, w, h;
      side = 1 << tile_log2();
      x    = int'($urandom_range(scr_w + side)) - side;
      y    = int'($urandom_range(scr_h + side)) - side;
      if ($urandom_range(7) == 0) begin
         w = $urandom_range(scr_w + 2 * side, 1);
         h = $urandom_range(scr_h + 2 * side, 1);
      end else begin
         w = $urandom_range(scr_w / 4 + side, 1);
         h = $urandom_range(scr_h / 4 + side, 1);
      end
      if (x > 4095) x = 4095;
      if (y > 4095) y = 4095;
      return make_req(MODE_MARK, x, y, w, h);
   endfunction

   // appends one item to the pending queue
   task automatic queue_req(tile_req_type rq);
      pending_req_q.insert(pending_req_q.size(), rq);
   endtask

   task automatic add_mark(int x, int y, int w, int h);
      queue_req(make_req(MODE_MARK, x, y, w, h));
   endtask

   // fetches carry random rectangle fields, which the block ignores
   task automatic add_fetch(int count);
      repeat (count)
         queue_req(make_req(MODE_FETCH, $urandom, $urandom, $urandom, $urandom));
   endtask

   // mostly marks followed by fetches, plus raw noise
   task automatic queue_traffic(int count);
      int added, k;
      added = 0;
      while (added < count) begin
         if ($urandom_range(99) < 25) begin
            queue_req(make_req(1'($urandom_range(1)), $urandom, $urandom,
                               $urandom, $urandom));
            added++;
         end else begin
            k = $urandom_range(4, 1);
            repeat (k) queue_req(rand_mark());
            added += k;
            k = ($urandom_range(4) == 0) ? $urandom_range(30, 8) : $urandom_range(6, 1);
            add_fetch(k);
            added += k;
         end
      end
   endtask

   // block idle: nothing queued or offered, nothing outstanding, ready up
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0 ||
             !req_ready);
   endtask

   task automatic set_screen(int w, int h, int sh);
      logic [CFG_W-1:0]     val [3];
      logic [CSR_IDX_W-1:0] idx [3];
      val = '{CFG_W'(w), CFG_W'(h), CFG_W'(sh)};
      idx = '{CSR_SCREEN_WIDTH, CSR_SCREEN_HEIGHT, CSR_TILE_SHIFT};
      for (int k = 0; k < 3; k++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      scr_w     = val[0];
      scr_h     = val[1];
      shift_cfg = val[2][SHIFT_W-1:0];
   endtask

   task automatic report_err(string msg);
      $display("ERROR: %s", msg);
      err_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_err($sformatf("response %0d: %s is %0d, expected %0d",
                              rsp_count, name, got, want));
   endtask

   // request driver: offers queued items and holds each until its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q.insert(expected_rsp_q.size(), apply_tile_request(offered_req));
            req_count <= req_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
               offered_req = pending_req_q.pop_front();
               req_mode    <= offered_req.mode;
               req_rect_x  <= offered_req.x;
               req_rect_y  <= offered_req.y;
               req_rect_w  <= offered_req.w;
               req_rect_h  <= offered_req.h;
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each transfer against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      tile_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_err($sformatf("response %0d arrived with none outstanding", rsp_count));
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("rect_accepted", rsp_rect_accepted, want.accepted);
               check_field("run_valid", rsp_run_valid, want.run_valid);
               check_field("run_x", rsp_run_x, want.run_x);
               check_field("run_y", rsp_run_y, want.run_y);
               check_field("run_w", rsp_run_w, want.run_w);
               check_field("run_h", rsp_run_h, want.run_h);
            end
            rsp_count++;
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
      end
   end

   // long receiver stalls so the output register fills and requests back up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((req_count == 30 || req_count == 300) && req_count != hold_tag) begin
         hold_left <= HOLD_CYCLES;
         hold_tag  <= req_count;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // default 640x480, 8-pixel tiles: empty fetch, empty rectangles, runs
      add_fetch(1);
      add_mark(10, 10, 0, 5);
      add_mark(10, 10, 5, 0);
      add_mark(-100, 0, 50, 10);
      add_mark(640, 0, 10, 10);
      add_mark(0, 480, 10, 10);
      add_mark(0, 0, 1, 1);
      add_mark(635, 475, 5, 5);
      add_mark(8, 0, 16, 1);
      add_fetch(1);
      add_mark(-5, 8, 13, 1);
      add_fetch(3);
      add_mark(-4096, -4096, 8191, 8191);
      add_fetch(2);
      add_mark(4095, 4095, 8191, 8191);
      queue_traffic(100);
      wait_idle();

      // oversized shift, screen not a multiple of the tile side
      set_screen(100, 50, 13'h1FFF);
      add_mark(96, 0, 4, 4);
      add_fetch(2);
      queue_traffic(50);
      wait_idle();

      // largest screen, 1-pixel tiles: scan limited by capacity
      set_screen(4096, 4096, 0);
      add_mark(4000, 1, 96, 1);
      add_mark(0, 2, 10, 1);
      add_fetch(2);
      queue_traffic(60);
      wait_idle();

      // narrower than one tile: no tile columns at all
      set_screen(15, 4096, 4);
      add_mark(0, 0, 15, 15);
      add_fetch(1);
      queue_traffic(20);
      wait_idle();

      // single-pixel screen
      set_screen(1, 1, 0);
      queue_traffic(40);
      wait_idle();

      // tall narrow screen, rows past capacity
      set_screen(8, 4096, 0);
      queue_traffic(60);
      wait_idle();

      set_screen(RST_WIDTH, RST_HEIGHT, RST_SHIFT);
      queue_traffic(30);
      wait_idle();

      repeat (300) @(posedge clock);
      @(negedge clock);
      if (err_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
